FILE: hdl/thre_pkg.sv
// shared types, character codes and helpers for the tagged hex record encoder
// no dependencies; every other file of the block refers to it by scoped names
package thre_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] LINE_LIMIT_RESET = 8'd74;
   localparam logic [7:0] LINE_LIMIT_MIN   = 8'd5;
   localparam logic [8:0] NEED_TAG5        = 9'd5;
   localparam logic [8:0] NEED_TAG3        = 9'd3;

   localparam logic       CSR_LINE_LIMIT    = 1'b0;
   localparam logic       CSR_FOOTER_ENABLE = 1'b1;

   localparam logic       MODE_DATA   = 1'b0;
   localparam logic       MODE_FINISH = 1'b1;

   localparam logic [7:0] CH_CLOSE  = 8'h37;  // '7'
   localparam logic [7:0] CH_END    = 8'h46;  // 'F'
   localparam logic [7:0] CH_ADDR   = 8'h39;  // '9'
   localparam logic [7:0] CH_PAIR   = 8'h42;  // 'B'
   localparam logic [7:0] CH_SINGLE = 8'h2A;  // '*'
   localparam logic [7:0] CH_FOOTER = 8'h3A;  // ':'
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NONE   = 8'h00;

   // one step of work for the back end, segments in output order
   typedef struct packed {
      logic        close1;     // close line before address tag
      logic        addr_tag;   // '9' + address
      logic        close2;     // close line before data tag or at finish
      logic        data;       // data tag present
      logic        pair;       // 'B' pair, else '*' single
      logic        footer;     // ':' newline
      logic        err;        // address error marker
      logic [15:0] address;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] code;
      if (nib < 4'd10) begin
         code = 8'h30 + {4'd0, nib};
      end else begin
         code = 8'h37 + {4'd0, nib};
      end
      return code;
   endfunction

endpackage

FILE: hdl/tagged_hex_record_encoder_core.sv
// tagged hex record encoder: data bytes in, tagged ascii text out, one char per beat
// a beat's text passes a queue slot, the back end command register and the result register
// throughput: one character per cycle out of the back end while the result is popped,
//   about 2.5 chars per data byte; the front end takes a beat per cycle until the queue fills
// reset: synchronous active high; line limit 74, footer on, address/column/checksum cleared
// depends on thre_pkg, thre_front, thre_fifo, thre_back
module tagged_hex_record_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = thre_pkg::QUEUE_DEPTH  // commands in flight, 2 or more
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        push,
   output logic        full,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_start_address,
   input  logic        req_first_in_record,
   input  logic        req_last_in_record,
   // result beats
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_of_run,
   output logic        rsp_address_error,
   // register writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   // command path from front to back end
   thre_pkg::cmd_type wr_cmd;
   thre_pkg::cmd_type rd_cmd;
   logic              wr_valid;
   logic              q_full;
   logic              rd_valid;
   logic              rd_pop;

   // front end classifies each beat and tracks the column so line breaks are
   // decided before the text is produced
   thre_front u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_start_address   (req_start_address),
      .req_first_in_record (req_first_in_record),
      .req_last_in_record  (req_last_in_record),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .q_full              (q_full),
      .q_wr_valid          (wr_valid),
      .q_wr_cmd            (wr_cmd)
   );

   // short queue lets the front keep accepting while text drains
   thre_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_cmd   (wr_cmd),
      .full     (q_full),
      .rd_valid (rd_valid),
      .rd_cmd   (rd_cmd),
      .rd_pop   (rd_pop)
   );

   // back end serializes characters and owns the line checksum
   thre_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_rd_valid        (rd_valid),
      .q_rd_cmd          (rd_cmd),
      .q_rd_pop          (rd_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_address_error (rsp_address_error)
   );

endmodule

FILE: hdl/thre_fifo.sv
// short command queue between the front end and the back end
// depends on thre_pkg for the command type
module thre_fifo #(
   parameter int unsigned DEPTH = thre_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  thre_pkg::cmd_type wr_cmd,
   output logic              full,
   output logic              rd_valid,
   output thre_pkg::cmd_type rd_cmd,
   input  logic              rd_pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   thre_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: hdl/thre_front.sv
// front end: accepts input beats, tracks address, pairing and column, and
// turns beats into commands, holding a byte back to pair it; depends on thre_pkg
module thre_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_mode,
   input  logic [7:0]        req_data_byte,
   input  logic [15:0]       req_start_address,
   input  logic              req_first_in_record,
   input  logic              req_last_in_record,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [7:0]        csr_write_data,
   input  logic              q_full,
   output logic              q_wr_valid,
   output thre_pkg::cmd_type q_wr_cmd
);

   logic [7:0]  line_limit_ff;
   logic        footer_enable_ff;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        holding_ff, holding_in;
   logic [16:0] next_address_ff, next_address_in;
   logic [7:0]  column_ff, column_in;
   logic        accept;
   thre_pkg::cmd_type cmd;

   assign full   = q_full;
   assign accept = push && !q_full;

   always_comb begin
      logic [8:0]  lim;
      logic [8:0]  col;
      logic [16:0] na;
      logic        hold;
      logic        ovf;
      lim  = {1'b0, (line_limit_ff < thre_pkg::LINE_LIMIT_MIN) ?
                    thre_pkg::LINE_LIMIT_MIN : line_limit_ff};
      col  = {1'b0, column_ff};
      na   = next_address_ff;
      hold = holding_ff;
      cmd  = '0;
      held_byte_in = held_byte_ff;
      ovf  = 1'b0;
      if (req_mode == thre_pkg::MODE_FINISH) begin
         hold       = 1'b0;
         cmd.close2 = (column_ff != '0);
         cmd.footer = footer_enable_ff;
         if (cmd.close2 || cmd.footer) begin
            col = '0;
         end
      end else begin
         if (req_first_in_record) begin
            hold = 1'b0;
            if (na != {1'b0, req_start_address}) begin
               na           = {1'b0, req_start_address};
               cmd.addr_tag = 1'b1;
               cmd.address  = req_start_address;
               cmd.close1   = (col + thre_pkg::NEED_TAG5) > lim;
               col          = (cmd.close1 ? 9'd0 : col) + thre_pkg::NEED_TAG5;
            end
         end
         ovf = na[16] || (hold && (na[15:0] == 16'hFFFF));
         if (ovf) begin
            cmd.err = 1'b1;
            if (req_last_in_record && hold) begin
               hold       = 1'b0;
               cmd.data   = 1'b1;
               cmd.byte0  = held_byte_ff;
               cmd.close2 = (col + thre_pkg::NEED_TAG3) > lim;
               col        = (cmd.close2 ? 9'd0 : col) + thre_pkg::NEED_TAG3;
               na         = na + 17'd1;
            end
         end else if (hold) begin
            hold       = 1'b0;
            cmd.data   = 1'b1;
            cmd.pair   = 1'b1;
            cmd.byte0  = held_byte_ff;
            cmd.byte1  = req_data_byte;
            cmd.close2 = (col + thre_pkg::NEED_TAG5) > lim;
            col        = (cmd.close2 ? 9'd0 : col) + thre_pkg::NEED_TAG5;
            na         = na + 17'd2;
         end else if (req_last_in_record) begin
            cmd.data   = 1'b1;
            cmd.byte0  = req_data_byte;
            cmd.close2 = (col + thre_pkg::NEED_TAG3) > lim;
            col        = (cmd.close2 ? 9'd0 : col) + thre_pkg::NEED_TAG3;
            na         = na + 17'd1;
         end else begin
            hold         = 1'b1;
            held_byte_in = req_data_byte;
         end
      end
      column_in       = col[7:0];
      next_address_in = na;
      holding_in      = hold;
   end

   assign q_wr_cmd   = cmd;
   assign q_wr_valid = accept && (cmd.close1 || cmd.addr_tag || cmd.close2 ||
                                  cmd.data || cmd.footer || cmd.err);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff    <= thre_pkg::LINE_LIMIT_RESET;
         footer_enable_ff <= 1'b1;
         holding_ff       <= 1'b0;
         next_address_ff  <= '0;
         column_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               thre_pkg::CSR_LINE_LIMIT: begin
                  line_limit_ff <= csr_write_data;
               end
               thre_pkg::CSR_FOOTER_ENABLE: begin
                  footer_enable_ff <= csr_write_data[0];
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            holding_ff      <= holding_in;
            next_address_ff <= next_address_in;
            column_ff       <= column_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

FILE: hdl/thre_back.sv
// back end: walks each command segment by segment, one character per cycle while the
// result is popped, keeps the line checksum and drives the result register; depends on thre_pkg
module thre_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_rd_valid,
   input  thre_pkg::cmd_type q_rd_cmd,
   output logic              q_rd_pop,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_of_run,
   output logic              rsp_address_error
);

   typedef enum logic [2:0] {
      SEG_CLOSE1 = 3'd0,
      SEG_ADDR   = 3'd1,
      SEG_CLOSE2 = 3'd2,
      SEG_DATA   = 3'd3,
      SEG_FOOTER = 3'd4,
      SEG_ERR    = 3'd5
   } seg_type;

   thre_pkg::cmd_type cmd_ff;
   logic        busy_ff;
   seg_type     seg_ff, seg_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] line_sum_ff;
   logic [15:0] cks_ff;
   logic        out_valid_ff;
   logic [7:0]  out_char_ff;
   logic        out_last_ff;
   logic        out_err_ff;

   logic        advance, seg_done, cmd_done, load;
   logic [7:0]  ch;
   logic        ch_err;
   logic [2:0]  seg_len;
   logic [15:0] word;
   logic [3:0]  nib;
   logic [5:0]  flags_cur, flags_new, rest;
   seg_type     next_seg, first_seg;

   function automatic seg_type lowest(input logic [5:0] v);
      seg_type s;
      s = SEG_ERR;
      for (int i = 5; i >= 0; i--) begin
         if (v[i]) begin
            s = seg_type'(3'(i));
         end
      end
      return s;
   endfunction

   function automatic logic [5:0] seg_flags(input thre_pkg::cmd_type c);
      return {c.err, c.footer, c.data, c.close2, c.addr_tag, c.close1};
   endfunction

   assign flags_cur = seg_flags(cmd_ff);
   assign flags_new = seg_flags(q_rd_cmd);
   assign rest      = flags_cur & 6'(6'b111110 << seg_ff);
   assign next_seg  = lowest(rest);
   assign first_seg = lowest(flags_new);

   // character generation for the current segment and position
   always_comb begin
      word = cks_ff;
      case (seg_ff)
         SEG_ADDR: word = cmd_ff.address;
         SEG_DATA: word = {cmd_ff.byte0, cmd_ff.byte1};
         default:  word = cks_ff;
      endcase
      case (idx_ff)
         3'd1:    nib = word[15:12];
         3'd2:    nib = word[11:8];
         3'd3:    nib = word[7:4];
         default: nib = word[3:0];
      endcase
      ch      = thre_pkg::hex_char(nib);
      ch_err  = 1'b0;
      seg_len = 3'd1;
      case (seg_ff)
         SEG_CLOSE1, SEG_CLOSE2: begin
            seg_len = 3'd7;
            if (idx_ff == 3'd0) begin
               ch = thre_pkg::CH_CLOSE;
            end else if (idx_ff == 3'd5) begin
               ch = thre_pkg::CH_END;
            end else if (idx_ff == 3'd6) begin
               ch = thre_pkg::CH_LF;
            end
         end
         SEG_ADDR: begin
            seg_len = 3'd5;
            if (idx_ff == 3'd0) begin
               ch = thre_pkg::CH_ADDR;
            end
         end
         SEG_DATA: begin
            seg_len = cmd_ff.pair ? 3'd5 : 3'd3;
            if (idx_ff == 3'd0) begin
               ch = cmd_ff.pair ? thre_pkg::CH_PAIR : thre_pkg::CH_SINGLE;
            end
         end
         SEG_FOOTER: begin
            seg_len = 3'd2;
            ch = (idx_ff == 3'd0) ? thre_pkg::CH_FOOTER : thre_pkg::CH_LF;
         end
         SEG_ERR: begin
            seg_len = 3'd1;
            ch      = thre_pkg::CH_NONE;
            ch_err  = 1'b1;
         end
         default: begin
            seg_len = 3'd1;
            ch      = thre_pkg::CH_NONE;
         end
      endcase
   end

   assign advance  = busy_ff && (!out_valid_ff || pop);
   assign seg_done = (idx_ff == seg_len - 3'd1);
   assign cmd_done = seg_done && (rest == '0);
   assign load     = q_rd_valid && (!busy_ff || (advance && cmd_done));
   assign q_rd_pop = load;

   always_comb begin
      seg_in = seg_ff;
      idx_in = idx_ff;
      if (load) begin
         seg_in = first_seg;
         idx_in = '0;
      end else if (advance) begin
         if (!seg_done) begin
            idx_in = idx_ff + 3'd1;
         end else begin
            seg_in = next_seg;
            idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         line_sum_ff  <= '0;
         seg_ff       <= SEG_CLOSE1;
         idx_ff       <= '0;
      end else begin
         seg_ff <= seg_in;
         idx_ff <= idx_in;
         if (load) begin
            busy_ff <= 1'b1;
         end else if (advance && cmd_done) begin
            busy_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         if (advance && !ch_err) begin
            if (ch == thre_pkg::CH_LF) begin
               line_sum_ff <= '0;
            end else begin
               line_sum_ff <= line_sum_ff + {8'd0, ch};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= q_rd_cmd;
      end
      if (advance) begin
         out_char_ff <= ch;
         out_last_ff <= cmd_done;
         out_err_ff  <= ch_err;
         // checksum covers the line including the closing '7'
         if ((seg_ff == SEG_CLOSE1 || seg_ff == SEG_CLOSE2) && idx_ff == 3'd0) begin
            cks_ff <= 16'd0 - (line_sum_ff + {8'd0, thre_pkg::CH_CLOSE});
         end
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_out_char      = out_char_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_address_error = out_err_ff;

endmodule
